@@ hw/rtl/prime_factorizer_trial_division_assert.svh @@
// Assertion macros for the prime factoriser checker.
// The clock clk_i and the active-low reset rst_ni must be visible where a macro is used.
`ifndef PRIME_FACTORIZER_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_FACTORIZER_TRIAL_DIVISION_ASSERT_SVH

// Plain property, sampled on the clock and disabled while in reset.
`define PFTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a condition to a consequence in the same cycle.
`define PFTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication from a condition to a consequence in the next cycle.
`define PFTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pftd_pkg.sv @@
// Shared constants and types for the trial-division prime factoriser.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package pftd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  // Width of the value and prime fields on the channels.
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned EXP_W          = 5;
  localparam logic [EXP_W-1:0] EXP_MAX   = 5'd31;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/pftd_if.sv @@
// Valid/ready channel interfaces for the factoriser input and result beats.
// Depends on pftd_pkg for the field widths.
`default_nettype none

interface pftd_in_if;
  import pftd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pftd_out_if;
  import pftd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] prime_factor;
  logic [EXP_W-1:0]   exponent;
  logic               last;
  logic               empty_res;
  modport source (output valid, output prime_factor, output exponent, output last,
                  output empty_res, input ready);
  modport sink   (input valid, input prime_factor, input exponent, input last,
                  input empty_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pftd_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by the factoriser sequencer.
// Depends on pftd_pkg for the status struct.
`default_nettype none

module pftd_divider #(
  parameter int unsigned N_W = 32,
  parameter int unsigned D_W = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [N_W-1:0]    dividend_i,
  input  wire logic [D_W-1:0]    divisor_i,
  output logic      [N_W-1:0]    quot_o,
  output pftd_pkg::div_sts_t     sts_o
);
  import pftd_pkg::*;

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W-1:0]   quot_q;
  logic [D_W-1:0]   rem_q;
  logic [D_W-1:0]   divisor_q;

  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             take;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_q, quot_q[N_W-1]};
    diff  = trial - {1'b0, divisor_q};
    take  = (trial >= {1'b0, divisor_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(N_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (run_q) begin
      rem_q  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
      quot_q <= {quot_q[N_W-2:0], take};
    end
  end

  assign quot_o         = quot_q;
  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

@@ hw/rtl/prime_factorizer_trial_division.sv @@
// Trial-division prime factoriser. Each division runs in the shared divider over VW bits
// (VW = min(VALUE_BITS, 32)); an item takes about sqrt(value) + number of prime factors
// divisions. An input of 0 or 1 gives its single result through the pending and result
// registers, with no division. One item is worked at a time; the result register lets
// the next item enter meanwhile. Asynchronous active-low reset returns the block to idle
// with no result pending.
`default_nettype none

module prime_factorizer_trial_division #(
  parameter int unsigned VALUE_BITS = pftd_pkg::VALUE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pftd_in_if.sink     in_i,
  pftd_out_if.source  out_o
);
  import pftd_pkg::*;

  localparam int unsigned VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  // Wide enough for one past the square root of the largest value.
  localparam int unsigned DW = (VW + 1) / 2 + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH,
    S_LAST
  } state_e;

  state_e           state_q;
  logic             start_q;
  logic [VW-1:0]    residue_q;
  logic [DW-1:0]    divisor_q;
  logic [EXP_W-1:0] mult_q;

  logic [VW-1:0]    cand_prime_q;
  logic [EXP_W-1:0] cand_exp_q;
  logic             cand_fin_q;

  logic             pend_vld_q;
  logic [VW-1:0]    pend_prime_q;
  logic [EXP_W-1:0] pend_exp_q;
  logic             pend_empty_q;

  logic             out_vld_q;
  logic [VW-1:0]    out_prime_q;
  logic [EXP_W-1:0] out_exp_q;
  logic             out_last_q;
  logic             out_empty_q;

  logic [VW-1:0]    quot;
  div_sts_t         div_sts;
  logic [VW-1:0]    in_value;
  logic             slot_free;
  logic             in_fire;
  logic             stop_div;
  logic             out_load;

  pftd_divider #(
    .N_W (VW),
    .D_W (DW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (residue_q),
    .divisor_i  (divisor_q),
    .quot_o     (quot),
    .sts_o      (div_sts)
  );

  assign in_value  = in_i.value[VW-1:0];
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_vld_q || out_o.ready;
  // Divisor squared exceeds the residue, checked on the first division by each divisor.
  assign stop_div  = (mult_q == '0) && (VW'(divisor_q) > quot);
  assign out_load  = slot_free && (((state_q == S_PUSH) && pend_vld_q) || (state_q == S_LAST));

  // A found prime waits in the pending register until it is known whether it is the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_q      <= 1'b0;
      residue_q    <= '0;
      divisor_q    <= '0;
      mult_q       <= '0;
      cand_prime_q <= '0;
      cand_exp_q   <= '0;
      cand_fin_q   <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_prime_q <= '0;
      pend_exp_q   <= '0;
      pend_empty_q <= 1'b0;
      out_vld_q    <= 1'b0;
      out_prime_q  <= '0;
      out_exp_q    <= '0;
      out_last_q   <= 1'b0;
      out_empty_q  <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && !out_o.ready);
      unique case (state_q)
        S_IDLE: begin
          start_q <= in_fire && (in_value > VW'(1));
          if (in_fire) begin
            residue_q <= in_value;
            mult_q    <= '0;
            if (in_value <= VW'(1)) begin
              divisor_q    <= '0;
              pend_vld_q   <= 1'b1;
              pend_prime_q <= '0;
              pend_exp_q   <= '0;
              pend_empty_q <= 1'b1;
              state_q      <= S_LAST;
            end else begin
              divisor_q <= DW'(2);
              state_q   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          start_q <= div_sts.done && !stop_div && (div_sts.rem_zero || (mult_q == '0));
          if (div_sts.done) begin
            if (stop_div) begin
              // Divisor squared exceeds the residue: what is left is prime or one.
              if (residue_q != VW'(1)) begin
                cand_prime_q <= residue_q;
                cand_exp_q   <= EXP_W'(1);
                cand_fin_q   <= 1'b1;
                state_q      <= S_PUSH;
              end else begin
                state_q <= S_LAST;
              end
            end else if (div_sts.rem_zero) begin
              residue_q <= quot;
              mult_q    <= (mult_q == EXP_MAX) ? mult_q : mult_q + EXP_W'(1);
            end else if (mult_q != '0) begin
              cand_prime_q <= VW'(divisor_q);
              cand_exp_q   <= mult_q;
              cand_fin_q   <= 1'b0;
              divisor_q    <= divisor_q + DW'(1);
              mult_q       <= '0;
              state_q      <= S_PUSH;
            end else begin
              divisor_q <= divisor_q + DW'(1);
            end
          end
        end
        S_PUSH: begin
          start_q <= (!pend_vld_q || slot_free) && !cand_fin_q;
          if (!pend_vld_q || slot_free) begin
            if (pend_vld_q) begin
              out_prime_q <= pend_prime_q;
              out_exp_q   <= pend_exp_q;
              out_last_q  <= 1'b0;
              out_empty_q <= pend_empty_q;
            end
            pend_vld_q   <= 1'b1;
            pend_prime_q <= cand_prime_q;
            pend_exp_q   <= cand_exp_q;
            pend_empty_q <= 1'b0;
            if (cand_fin_q) begin
              state_q <= S_LAST;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_LAST: begin
          start_q <= 1'b0;
          if (slot_free) begin
            out_prime_q <= pend_prime_q;
            out_exp_q   <= pend_exp_q;
            out_last_q  <= 1'b1;
            out_empty_q <= pend_empty_q;
            pend_vld_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          start_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.prime_factor = FIELD_W'(out_prime_q);
  assign out_o.exponent     = out_exp_q;
  assign out_o.last         = out_last_q;
  assign out_o.empty_res    = out_empty_q;

endmodule

`default_nettype wire

@@ hw/rtl/pftd_checker.sv @@
// Port-level checks for the prime factoriser, bound to the top level.
// Depends on pftd_pkg and the assertion macro header.
`default_nettype none

`include "prime_factorizer_trial_division_assert.svh"

module pftd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [pftd_pkg::FIELD_W-1:0] out_prime_i,
  input wire logic [pftd_pkg::EXP_W-1:0]  out_exp_i,
  input wire logic                        out_last_i,
  input wire logic                        out_empty_i
);
  import pftd_pkg::*;

  logic out_stall;
  logic in_take;
  logic empty_beat;
  logic factor_beat;
  logic empty_ok;
  logic factor_ok;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign in_take     = in_valid_i && in_ready_i;
  assign empty_beat  = out_valid_i && out_empty_i;
  assign factor_beat = out_valid_i && !out_empty_i;
  assign empty_ok    = out_last_i && (out_prime_i == '0) && (out_exp_i == '0);
  assign factor_ok   = (out_prime_i > FIELD_W'(1)) && (out_exp_i != '0);

  // A stalled result beat must stay on offer.
  `PFTD_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result beat dropped while stalled")

  // An empty result closes its run and carries no factor.
  `PFTD_ASSERT_IMPL(a_empty_form, empty_beat, empty_ok, "malformed empty result")

  // A real factor is at least two and occurs at least once.
  `PFTD_ASSERT_IMPL(a_factor_form, factor_beat, factor_ok, "malformed factor result")

  // Once a value is taken the block is busy with it for at least the next cycle.
  `PFTD_ASSERT_NEXT(a_busy_after_take, in_take, !in_ready_i, "input taken on consecutive cycles")

endmodule

bind prime_factorizer_trial_division pftd_checker u_pftd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_prime_i (out_o.prime_factor),
  .out_exp_i   (out_o.exponent),
  .out_last_i  (out_o.last),
  .out_empty_i (out_o.empty_res)
);

`default_nettype wire

@@ test/prime_factorizer_trial_division_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the trial-division prime factoriser. It needs pftd_pkg,
// the pftd_if channel interfaces and the prime_factorizer_trial_division RTL.
// Every result beat is checked against the typed beat or a local factorisation of its value.

module prime_factorizer_trial_division_tb;
  import pftd_pkg::*;

  localparam int unsigned MAX_BEATS       = 9;
  localparam int unsigned PHASE_VALUES    = 20;
  localparam int unsigned WATCHDOG_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic [FIELD_W-1:0] prime_factor;
    logic [EXP_W-1:0]   exponent;
    logic               last;
    logic               empty_res;
  } factor_beat_t;

  typedef struct {
    logic [FIELD_W-1:0] value;
    bit                 typed;
    factor_beat_t       beat;
  } directed_row_t;

  localparam factor_beat_t NO_BEAT = '{'0, '0, 1'b0, 1'b0};

  logic clk_i;
  logic rst_ni;

  pftd_in_if  in_if ();
  pftd_out_if out_if ();

  prime_factorizer_trial_division dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Rows with a typed beat are single-result cases that can be read off directly.
  directed_row_t directed_rows [19] = '{
    '{32'd0,          1'b1, '{32'd0, 5'd0,  1'b1, 1'b1}},
    '{32'd1,          1'b1, '{32'd0, 5'd0,  1'b1, 1'b1}},
    '{32'd2,          1'b1, '{32'd2, 5'd1,  1'b1, 1'b0}},
    '{32'd3,          1'b1, '{32'd3, 5'd1,  1'b1, 1'b0}},
    '{32'd4,          1'b1, '{32'd2, 5'd2,  1'b1, 1'b0}},
    '{32'h8000_0000,  1'b1, '{32'd2, 5'd31, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF,  1'b0, NO_BEAT},
    '{32'd223092870,  1'b0, NO_BEAT},
    '{32'd3486784401, 1'b0, NO_BEAT},
    '{32'd6,          1'b0, NO_BEAT},
    '{32'd49,         1'b0, NO_BEAT},
    '{32'd9409,       1'b0, NO_BEAT},
    '{32'd65537,      1'b0, NO_BEAT},
    '{32'd999983,     1'b0, NO_BEAT},
    '{32'h5555_5555,  1'b0, NO_BEAT},
    '{32'hAAAA_AAAA,  1'b0, NO_BEAT},
    '{32'd1048573,    1'b0, NO_BEAT},
    '{32'hFFFE_0001,  1'b0, NO_BEAT},
    '{32'h7FFF_8000,  1'b0, NO_BEAT}
  };

  int unsigned low_primes [25] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79,
    83, 89, 97
  };

  factor_beat_t expected_factors [$];
  int unsigned  values_sent;
  int unsigned  beats_checked;
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one beat to the tail of the expected queue.
  function automatic void enqueue_beat(input factor_beat_t beat);
    expected_factors.insert(expected_factors.size(), beat);
  endfunction

  // Factorise one value and queue the beats the block should return for it.
  function automatic void queue_factors(input logic [FIELD_W-1:0] value);
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     count;
    int unsigned     found;
    factor_beat_t    beat;
    if (value <= 1) begin
      beat = '{'0, '0, 1'b1, 1'b1};
      enqueue_beat(beat);
      return;
    end
    rest    = value;
    divisor = 2;
    found   = 0;
    while (divisor <= rest / divisor) begin
      count = 0;
      while (rest % divisor == 0) begin
        rest = rest / divisor;
        if (count < EXP_MAX) count++;
      end
      if (count != 0 && found < MAX_BEATS) begin
        beat = '{divisor[FIELD_W-1:0], count[EXP_W-1:0], 1'b0, 1'b0};
        enqueue_beat(beat);
        found++;
      end
      divisor++;
    end
    if (rest != 1 && found < MAX_BEATS) begin
      beat = '{rest[FIELD_W-1:0], EXP_W'(1), 1'b0, 1'b0};
      enqueue_beat(beat);
    end
    expected_factors[$].last = 1'b1;
  endfunction

  // Mostly smooth numbers so that long runs stay rare; a few 0s, 1s and plain values up to 2^20.
  function automatic logic [FIELD_W-1:0] random_value();
    longint unsigned acc;
    longint unsigned ceiling;
    longint unsigned prime;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return FIELD_W'($urandom_range(0, 1));
    if (pick < 15) return FIELD_W'($urandom_range(2, 1 << 20));
    ceiling = 64'd1 << $urandom_range(2, 32);
    acc     = $urandom_range(1, 4095);
    if (acc >= ceiling) acc = 1;
    repeat (40) begin
      prime = low_primes[$urandom_range(0, 24)];
      if (acc * prime < ceiling) acc = acc * prime;
    end
    return acc[FIELD_W-1:0];
  endfunction

  task automatic send_value(input logic [FIELD_W-1:0] value, input bit typed,
                            input factor_beat_t typed_beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (typed) enqueue_beat(typed_beat);
    else queue_factors(value);
    values_sent++;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_beats
    factor_beat_t want;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        beats_checked++;
        if (expected_factors.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat prime %0d exponent %0d last %0b empty %0b",
                   $time, out_if.prime_factor, out_if.exponent, out_if.last,
                   out_if.empty_res);
        end else begin
          want = expected_factors.pop_front();
          if (out_if.prime_factor !== want.prime_factor) begin
            mismatches++;
            $display("%0t: prime_factor expected %0d actual %0d", $time,
                     want.prime_factor, out_if.prime_factor);
          end
          if (out_if.exponent !== want.exponent) begin
            mismatches++;
            $display("%0t: exponent of %0d expected %0d actual %0d", $time,
                     want.prime_factor, want.exponent, out_if.exponent);
          end
          if (out_if.last !== want.last) begin
            mismatches++;
            $display("%0t: last for %0d expected %0b actual %0b", $time,
                     want.prime_factor, want.last, out_if.last);
          end
          if (out_if.empty_res !== want.empty_res) begin
            mismatches++;
            $display("%0t: empty_res expected %0b actual %0b", $time,
                     want.empty_res, out_if.empty_res);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: watchdog, no beat in %0d cycles, %0d beats outstanding", $time,
                 quiet_cycles, expected_factors.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    values_sent   = 0;
    beats_checked = 0;
    mismatches    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].beat);
    end

    // Free running, sender gaps, receiver stalls, then both at once.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 37 : 0;
      stall_pct     = (phase == 2) ? 49 : (phase == 3) ? 37 : 0;
      repeat (PHASE_VALUES) send_value(random_value(), 1'b0, NO_BEAT);
    end
    in_if.valid <= 1'b0;

    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Factorised %0d values (%0d directed, the rest random), %0d result beats checked.",
             values_sent, $size(directed_rows), beats_checked);
    $display("Handshake pressure ran free, then with sender gaps, receiver stalls and both.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
